>>> hw/rtl/rhp_pkg.sv
// shared types and constants of the rtp header parser
`timescale 1ns / 1ps

package rhp_pkg;

   localparam logic [1:0] RTP_VERSION = 2'd2;
   localparam logic [7:0] RTCP_LO     = 8'd200;
   localparam logic [7:0] RTCP_HI     = 8'd204;
   localparam int         FIXED_HDR   = 12;

   // register indexes of the csr port
   localparam logic CSR_EXPECTED_TYPE = 1'b0;
   localparam logic CSR_G711_MODE     = 1'b1;

   // result queue geometry
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_RTCP        = 3'd1,
      ST_BAD_VERSION = 3'd2,
      ST_TOO_SHORT   = 3'd3,
      ST_WRONG_TYPE  = 3'd4,
      ST_TOO_LONG    = 3'd5
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      status_type  status;
      logic [15:0] sequence_res;
      logic [31:0] timestamp;
      logic [12:0] payload_length;
      logic        sequence_gap;
      logic        end_of_run;
   } rsp_item_type;

   // up to two results per input beat: payload byte first, summary second
   typedef struct packed {
      logic         first_valid;
      rsp_item_type first;
      logic         second_valid;
      rsp_item_type second;
   } result_pair_type;

endpackage

>>> hw/rtl/rhp_parser.sv
// header decode, payload gating and packet summary for one input beat
`timescale 1ns / 1ps

module rhp_parser #(
   parameter int MAX_PAYLOAD = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic                     csr_index,
   input  logic [7:0]               csr_wdata,
   input  logic                     beat_accept,
   input  logic [7:0]               data_byte,
   input  logic                     last_byte,
   output rhp_pkg::result_pair_type results
);
   import rhp_pkg::*;

   localparam int CW = $clog2(MAX_PAYLOAD + 2);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_PAYLOAD);

   logic [15:0]   pos_ff, pos_in;
   logic [3:0]    csrc_ff, csrc_in;
   logic          ext_present_ff, ext_present_in;
   logic [15:0]   ext_words_ff, ext_words_in;
   logic [1:0]    flags_ff, flags_in;          // bit0 bad version, bit1 rtcp
   logic [6:0]    type_ff, type_in;
   logic [15:0]   seq_ff, seq_in;
   logic [31:0]   ts_ff, ts_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   prev_seq_ff, prev_seq_in;
   logic [7:0]    exp_type_ff;
   logic          g711_ff;

   logic          bad_hit, rtcp_hit;
   logic [6:0]    base;
   logic [18:0]   start;
   logic          in_payload, count_below, type_ok, pay_fire, over;
   logic [16:0]   total;
   logic          too_short, gap;
   logic [CW-1:0] len;
   status_type    status;

   always_comb begin
      bad_hit  = (pos_ff == 16'd0) && (data_byte[7:6] != RTP_VERSION);
      rtcp_hit = (pos_ff == 16'd1) && (data_byte inside {[RTCP_LO:RTCP_HI]});
      flags_in = flags_ff | {rtcp_hit, bad_hit};

      csrc_in        = (pos_ff == 16'd0) ? data_byte[3:0] : csrc_ff;
      ext_present_in = (pos_ff == 16'd0) ? data_byte[4] : ext_present_ff;
      type_in        = (pos_ff == 16'd1) ? data_byte[6:0] : type_ff;
      seq_in = (pos_ff == 16'd2 || pos_ff == 16'd3) ? {seq_ff[7:0], data_byte} : seq_ff;
      ts_in  = (pos_ff >= 16'd4 && pos_ff < 16'd8) ? {ts_ff[23:0], data_byte} : ts_ff;

      base = 7'(FIXED_HDR) + {1'b0, csrc_in, 2'b00};
      ext_words_in = ext_words_ff;
      if (ext_present_in) begin
         if (pos_ff == 16'(base) + 16'd2)
            ext_words_in = {data_byte, 8'h00};
         else if (pos_ff == 16'(base) + 16'd3)
            ext_words_in = {ext_words_ff[15:8], data_byte};
      end
      start = 19'(base) + (ext_present_in ? (19'd4 + {1'b0, ext_words_in, 2'b00}) : 19'd0);

      in_payload  = {3'b000, pos_ff} >= start;
      type_ok     = {1'b0, type_in} == exp_type_ff;
      count_below = count_ff < MAX_C;
      pay_fire    = in_payload && count_below && (flags_in == 2'b00) && type_ok;
      if (!in_payload)
         count_in = count_ff;
      else if (count_below)
         count_in = count_ff + 1'b1;
      else
         count_in = MAX_C + 1'b1;

      over      = count_in > MAX_C;
      len       = over ? MAX_C : count_in;
      total     = {1'b0, pos_ff} + 17'd1;
      too_short = (total < 17'(FIXED_HDR)) || ({2'b00, total} < start);

      if (flags_in[0])
         status = ST_BAD_VERSION;
      else if (flags_in[1])
         status = ST_RTCP;
      else if (too_short)
         status = ST_TOO_SHORT;
      else if (!type_ok)
         status = ST_WRONG_TYPE;
      else if (over)
         status = ST_TOO_LONG;
      else
         status = ST_OK;

      gap = g711_ff && (status == ST_OK) && (prev_seq_ff != 16'd0)
            && (seq_in != prev_seq_ff + 16'd1);
      prev_seq_in = (g711_ff && status == ST_OK) ? seq_in : prev_seq_ff;
      pos_in = (pos_ff != 16'hFFFF) ? pos_ff + 16'd1 : pos_ff;

      results.first_valid          = beat_accept && pay_fire;
      results.first.kind           = KIND_PAYLOAD;
      results.first.payload_byte   = data_byte;
      results.first.status         = ST_OK;
      results.first.sequence_res   = 16'd0;
      results.first.timestamp      = 32'd0;
      results.first.payload_length = 13'd0;
      results.first.sequence_gap   = 1'b0;
      results.first.end_of_run     = !last_byte;

      results.second_valid          = beat_accept && last_byte;
      results.second.kind           = KIND_SUMMARY;
      results.second.payload_byte   = 8'd0;
      results.second.status         = status;
      results.second.sequence_res   = seq_in;
      results.second.timestamp      = ts_in;
      results.second.payload_length = 13'(len);
      results.second.sequence_gap   = gap;
      results.second.end_of_run     = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         csrc_ff        <= '0;
         ext_present_ff <= 1'b0;
         ext_words_ff   <= '0;
         flags_ff       <= '0;
         type_ff        <= '0;
         seq_ff         <= '0;
         ts_ff          <= '0;
         count_ff       <= '0;
         prev_seq_ff    <= '0;
         exp_type_ff    <= 8'd128;
         g711_ff        <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_EXPECTED_TYPE: exp_type_ff <= csr_wdata;
               CSR_G711_MODE:     g711_ff     <= csr_wdata[0];
               default:           ;
            endcase
         end
         if (beat_accept) begin
            if (last_byte) begin
               pos_ff         <= '0;
               csrc_ff        <= '0;
               ext_present_ff <= 1'b0;
               ext_words_ff   <= '0;
               flags_ff       <= '0;
               type_ff        <= '0;
               seq_ff         <= '0;
               ts_ff          <= '0;
               count_ff       <= '0;
               prev_seq_ff    <= prev_seq_in;
            end else begin
               pos_ff         <= pos_in;
               csrc_ff        <= csrc_in;
               ext_present_ff <= ext_present_in;
               ext_words_ff   <= ext_words_in;
               flags_ff       <= flags_in;
               type_ff        <= type_in;
               seq_ff         <= seq_in;
               ts_ff          <= ts_in;
               count_ff       <= count_in;
            end
         end
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      beat_accept && last_byte |=> pos_ff == 16'd0 && count_ff == '0 && flags_ff == 2'b00)
      else $error("packet state not cleared after last beat");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_C + 1'b1)
      else $error("payload count beyond saturation value");

   a_no_forward_rejected: assert property (@(posedge clock) disable iff (reset)
      results.first_valid |-> flags_in == 2'b00 && type_ok && count_ff < MAX_C)
      else $error("payload forwarded from a rejected packet");

   a_gap_needs_ok: assert property (@(posedge clock) disable iff (reset)
      results.second_valid && results.second.sequence_gap
      |-> g711_ff && results.second.status == ST_OK)
      else $error("sequence gap flagged outside g711 ok packet");

endmodule

>>> hw/rtl/rhp_result_fifo.sv
// result queue, up to two writes and one read per cycle
`timescale 1ns / 1ps

module rhp_result_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  rhp_pkg::result_pair_type push,
   input  logic                     pop,
   output rhp_pkg::rsp_item_type    head,
   output logic                     not_empty,
   output logic                     full
);
   import rhp_pkg::*;

   rsp_item_type          mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [FIFO_PTR_W-1:0] second_addr;
   logic [1:0]            n_push;
   logic                  do_pop;

   always_comb begin
      do_pop      = pop && (count_ff != '0);
      n_push      = {1'b0, push.first_valid} + {1'b0, push.second_valid};
      second_addr = push.first_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      wr_ptr_in   = wr_ptr_ff + FIFO_PTR_W'(n_push);
      rd_ptr_in   = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in    = count_ff + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(do_pop);
      head        = mem[rd_ptr_ff];
      not_empty   = count_ff != '0;
      // room for two results is needed before a beat is taken
      full        = count_ff > FIFO_CNT_W'(FIFO_DEPTH - 2);
   end

   always_ff @(posedge clock) begin
      if (push.first_valid)
         mem[wr_ptr_ff] <= push.first;
      if (push.second_valid)
         mem[second_addr] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue count beyond depth");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      FIFO_PTR_W'(wr_ptr_ff - rd_ptr_ff) == count_ff[FIFO_PTR_W-1:0])
      else $error("result queue pointers disagree with count");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.first_valid || push.second_valid) |-> !full)
      else $error("result written while queue lacks room");

endmodule

>>> hw/rtl/rtp_header_parser_unit.sv
// top level of the rtp header parser and payload forwarder
`timescale 1ns / 1ps

// receives an rtp packet one byte per beat (req_last_byte on its final byte),
// decodes the fixed header, skips csrc words and the header extension and
// forwards payload bytes as rsp beats of kind payload; the final byte also
// yields a summary beat with status, sequence, timestamp, length and the g711
// sequence gap flag. one input beat is taken every cycle while req_stall is
// low: the whole decode of a byte sits between the packet state registers and
// a four-entry result queue. a final byte that is also a forwarded payload
// byte puts two beats in the queue, which drain at one per cycle while
// rsp_stall is low; req_stall is high while fewer than two queue slots are
// free. the next byte after a final byte is a header byte that adds at most
// one beat, so the queue never holds more than two beats and the input never
// stalls while the output side never stalls. configuration goes through the
// csr write port (index 0 expected payload type, index 1 g711 mode); the user
// must write it only while the block is idle; the block does not enforce it.
module rtp_header_parser_unit #(
   parameter int MAX_PAYLOAD = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   // packet bytes
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_sequence_res,
   output logic [31:0] rsp_timestamp,
   output logic [12:0] rsp_payload_length,
   output logic        rsp_sequence_gap,
   output logic        rsp_end_of_run
);
   import rhp_pkg::*;

   result_pair_type results;
   rsp_item_type    head;
   logic            beat_accept;
   logic            queue_full;
   logic            queue_not_empty;

   assign req_stall   = queue_full;
   assign beat_accept = req_valid && !queue_full;

   rhp_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .beat_accept (beat_accept),
      .data_byte   (req_data_byte),
      .last_byte   (req_last_byte),
      .results     (results)
   );

   rhp_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (results),
      .pop       (rsp_valid && !rsp_stall),
      .head      (head),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   // output beat comes straight from the queue head register
   assign rsp_valid          = queue_not_empty;
   assign rsp_kind           = head.kind;
   assign rsp_payload_byte   = head.payload_byte;
   assign rsp_status         = head.status;
   assign rsp_sequence_res   = head.sequence_res;
   assign rsp_timestamp      = head.timestamp;
   assign rsp_payload_length = head.payload_length;
   assign rsp_sequence_gap   = head.sequence_gap;
   assign rsp_end_of_run     = head.end_of_run;

   a_summary_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SUMMARY |-> rsp_end_of_run)
      else $error("summary beat without end of run");

   a_payload_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PAYLOAD |-> rsp_status == ST_OK
      && rsp_payload_length == 13'd0 && !rsp_sequence_gap)
      else $error("payload beat carries summary fields");

   a_accept_makes_room: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_byte |=> rsp_valid)
      else $error("last byte accepted but no result queued");

endmodule
